[hw/rtl/linear_interp_resampler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// The macros wrap concurrent assertions on i_clk with the active-low reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define LIR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lir assertion failed");
`define LIR_ASSERT_NEVER(label, cond) `LIR_ASSERT(label, !(cond))
`else
`define LIR_ASSERT(label, prop)
`define LIR_ASSERT_NEVER(label, cond)
`endif

`endif

[hw/rtl/lir_pkg.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Widths, constants and request types shared by the resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int STEP_W          = 36;
    localparam int PHASE_W         = 40;
    localparam int PHASE_FRAC_BITS = 32;
    localparam int MAX_OUTPUTS     = 16;
    localparam int COUNT_W         = $clog2(MAX_OUTPUTS + 1);
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int PROD_W          = DIFF_W + PHASE_FRAC_BITS + 1;
    localparam int SUM_W           = PROD_W + 1;
    localparam int STEP_SHIFT      = 32 - PHASE_FRAC_BITS;

    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(64'd1 << 32);
    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << PHASE_FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last_of_run;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_MUL   = 5'b00100,
        S_ACC   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

[hw/rtl/linear_interp_resampler_unit.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Each input request is one stereo frame. After the first frame, every frame
// produces zero to sixteen interpolated output requests; the last one of a
// frame carries last_of_run. One signed multiplier and one adder are shared
// by both channels, so each output takes a check, a multiply and an accumulate
// per channel, and a load of the output register, which waits while the output
// is stalled. The input is stalled while a frame is being processed. The first
// frame after reset produces no outputs and only stores its samples.
// The step register is written while the block is idle.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_unit_defines.svh"

module linear_interp_resampler_unit
    import lir_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [STEP_W-1:0] i_cfg_data
);

    t_state                     r_state, n_state;
    logic [STEP_W-1:0]          r_step;
    logic [PHASE_W-1:0]         r_phase, n_phase;
    logic                       r_have_prev, n_have_prev;
    logic [COUNT_W-1:0]         r_count, n_count;
    logic                       r_chan, n_chan;
    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r, r_next_l, r_next_r;
    logic signed [SAMPLE_W-1:0] r_res_l, r_res_r;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic                       w_in_acc;
    logic                       w_out_free;
    logic [PHASE_W-1:0]         w_step;
    logic [PHASE_W-1:0]         w_phase_add;
    logic                       w_run;
    logic                       w_last;
    logic signed [SAMPLE_W-1:0] w_prev_sel, w_next_sel;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [PHASE_FRAC_BITS:0] w_frac;
    logic signed [SUM_W-1:0]    w_num;
    logic signed [SAMPLE_W-1:0] w_floor;
    logic                       w_round_up;
    logic signed [SAMPLE_W-1:0] w_res;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step      = PHASE_W'(r_step >> STEP_SHIFT);
    assign w_phase_add = r_phase + w_step;
    assign w_run       = (r_phase < PHASE_ONE) && (r_count < COUNT_W'(MAX_OUTPUTS));
    assign w_last      = (w_phase_add >= PHASE_ONE)
                         || (r_count == COUNT_W'(MAX_OUTPUTS - 1));

    assign w_prev_sel = r_chan ? r_prev_r : r_prev_l;
    assign w_next_sel = r_chan ? r_next_r : r_next_l;
    assign w_diff     = $signed({w_next_sel[SAMPLE_W-1], w_next_sel})
                        - $signed({w_prev_sel[SAMPLE_W-1], w_prev_sel});
    assign w_frac     = $signed({1'b0, r_phase[PHASE_FRAC_BITS-1:0]});

    assign w_num      = $signed({{(SUM_W - SAMPLE_W - PHASE_FRAC_BITS){w_prev_sel[SAMPLE_W-1]}},
                                 w_prev_sel, {PHASE_FRAC_BITS{1'b0}}})
                        + $signed({r_prod[PROD_W-1], r_prod});
    assign w_floor    = w_num[PHASE_FRAC_BITS +: SAMPLE_W];
    assign w_round_up = w_num[SUM_W-1] && (|w_num[PHASE_FRAC_BITS-1:0]);
    assign w_res      = w_floor + SAMPLE_W'(w_round_up);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_have_prev = r_have_prev;
        n_count     = r_count;
        n_chan      = r_chan;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_have_prev = 1'b1;
                    n_count     = '0;
                    n_chan      = 1'b0;
                    if (r_have_prev) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_chan = 1'b0;
                if (w_run) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                    n_phase = (r_phase >= PHASE_ONE) ? r_phase - PHASE_ONE : '0;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_chan) begin
                    n_state = S_EMIT;
                end else begin
                    n_chan  = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_phase = w_phase_add;
                    n_count = r_count + COUNT_W'(1);
                    n_state = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_RESET;
            r_phase     <= '0;
            r_have_prev <= 1'b0;
            r_count     <= '0;
            r_chan      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_have_prev <= n_have_prev;
            r_count     <= n_count;
            r_chan      <= n_chan;
            if (i_cfg_valid && o_cfg_ready) begin
                r_step <= i_cfg_data;
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc && !r_have_prev) begin
                r_prev_l <= i_in_data.left_sample;
                r_prev_r <= i_in_data.right_sample;
            end else if (r_state == S_CHECK && !w_run) begin
                r_prev_l <= r_next_l;
                r_prev_r <= r_next_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_next_l <= i_in_data.left_sample;
            r_next_r <= i_in_data.right_sample;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_diff * w_frac;
        end
        if (r_state == S_ACC) begin
            if (r_chan) begin
                r_res_r <= w_res;
            end else begin
                r_res_l <= w_res;
            end
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out_data.left_out    <= r_res_l;
            r_out_data.right_out   <= r_res_r;
            r_out_data.last_of_run <= w_last;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `LIR_ASSERT_NEVER(a_count_bound, r_count > COUNT_W'(MAX_OUTPUTS))
    `LIR_ASSERT(a_emit_loads, (r_state == S_EMIT && w_out_free) |=> (o_out_valid && r_state == S_CHECK))
    `LIR_ASSERT(a_first_frame_silent, (w_in_acc && !r_have_prev) |=> (r_state == S_IDLE && r_have_prev))
    `LIR_ASSERT(a_out_from_emit, $rose(o_out_valid) |-> $past(r_state == S_EMIT))

endmodule
